FILE: hdl/dems_pkg.sv
// shared types, codes and defaults for the dual endpoint mailbox scheduler
package dems_pkg;

    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int TRACE_LIMIT_DEF = 256;
    localparam int CMD_DEPTH       = 2;

    // request codes on the input channel
    localparam logic [1:0] REQ_BOOT     = 2'd0;
    localparam logic [1:0] REQ_SEND     = 2'd1;
    localparam logic [1:0] REQ_TURN     = 2'd2;
    localparam logic [1:0] REQ_RUN_DONE = 2'd3;

    // event kinds on the output channel
    localparam logic [2:0] EV_BOOT     = 3'd0;
    localparam logic [2:0] EV_TURN     = 3'd1;
    localparam logic [2:0] EV_SEND     = 3'd2;
    localparam logic [2:0] EV_FULL     = 3'd3;
    localparam logic [2:0] EV_DELIVER  = 3'd4;
    localparam logic [2:0] EV_IDLE     = 3'd5;
    localparam logic [2:0] EV_WRITABLE = 3'd6;
    localparam logic [2:0] EV_FAULT    = 3'd7;

    // fault codes
    localparam logic [2:0] FLT_NONE  = 3'd0;
    localparam logic [2:0] FLT_LIMIT = 3'd1;
    localparam logic [2:0] FLT_NO_RX = 3'd2;
    localparam logic [2:0] FLT_NO_WR = 3'd3;
    localparam logic [2:0] FLT_TRACE = 3'd4;

    typedef enum logic [1:0] {
        CMD_BOOT,
        CMD_SEND,
        CMD_TURN,
        CMD_LIMIT
    } cmd_op_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_EXEC,
        BK_EMIT
    } back_state_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic        endpoint;
        logic [7:0]  msg_length;
        logic [63:0] msg_payload;
        logic        receive_vector_set;
        logic        writable_vector_set;
        logic        hit_limit;
    } req_item_t;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic        event_endpoint;
        logic        peer_endpoint;
        logic [7:0]  out_length;
        logic [63:0] out_payload;
        logic [2:0]  fault_code;
        logic        step_ok;
        logic        last;
    } evt_item_t;

    typedef struct packed {
        cmd_op_t     op;
        logic        endpoint;
        logic [7:0]  msg_length;
        logic [63:0] msg_payload;
        logic        rx_vec;
        logic        wr_vec;
    } cmd_t;

endpackage

FILE: hdl/dems_front.sv
// front end: accepts request transactions, classifies them and queues commands
module dems_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  dems_pkg::req_item_t req,
    output logic              cmd_valid,
    input  logic              cmd_pop,
    output dems_pkg::cmd_t    cmd
);

    localparam int PTR_W = $clog2(dems_pkg::CMD_DEPTH);
    localparam int CNT_W = $clog2(dems_pkg::CMD_DEPTH + 1);

    dems_pkg::cmd_t   cmd_q [dems_pkg::CMD_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    dems_pkg::cmd_t   cls;
    logic             keep;
    logic             push;

    // classify: a run that finished without hitting the limit changes nothing
    always_comb
    begin
        cls.endpoint    = req.endpoint;
        cls.msg_length  = req.msg_length;
        cls.msg_payload = req.msg_payload;
        cls.rx_vec      = req.receive_vector_set;
        cls.wr_vec      = req.writable_vector_set;
        keep            = 1'b1;
        case (req.req_type)
            dems_pkg::REQ_BOOT: cls.op = dems_pkg::CMD_BOOT;
            dems_pkg::REQ_SEND: cls.op = dems_pkg::CMD_SEND;
            dems_pkg::REQ_TURN: cls.op = dems_pkg::CMD_TURN;
            default:
            begin
                cls.op = dems_pkg::CMD_LIMIT;
                keep   = req.hit_limit;
            end
        endcase
    end

    assign req_ready = (fill_reg != CNT_W'(dems_pkg::CMD_DEPTH));
    assign push      = req_valid && req_ready && keep;
    assign cmd_valid = (fill_reg != '0);
    assign cmd       = cmd_q[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !cmd_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (!push && cmd_pop)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            cmd_q[wr_ptr_reg] <= cls;
        end
    end

endmodule

FILE: hdl/dems_back.sv
// back end: executes queued commands against the mailbox state and emits events
module dems_back #(
    parameter int QUEUE_DEPTH = dems_pkg::QUEUE_DEPTH_DEF,
    parameter int TRACE_LIMIT = dems_pkg::TRACE_LIMIT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_pop,
    input  dems_pkg::cmd_t       cmd,
    output logic                 evt_valid,
    input  logic                 evt_ready,
    output dems_pkg::evt_item_t  evt,
    output logic                 faulted
);

    localparam int SLOT_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int EVC_W     = $clog2(TRACE_LIMIT + 1);
    localparam int MEM_DEPTH = 2 * (1 << SLOT_W);
    localparam int ENTRY_W   = 8 + 64;

    typedef struct packed {
        dems_pkg::evt_item_t res;
        logic [EVC_W-1:0]    evc;
        logic [2:0]          fault;
        logic                tf;
    } rec_step_t;

    // one event record against the trace budget
    function automatic rec_step_t record_event(
        input logic [2:0]       kind,
        input logic             ep,
        input logic             peer,
        input logic [7:0]       len,
        input logic [63:0]      pay,
        input logic [EVC_W-1:0] evc,
        input logic [2:0]       flt,
        input logic             tf
    );
        rec_step_t s;
        s       = '0;
        s.evc   = evc;
        s.fault = flt;
        s.tf    = tf;
        if (evc >= EVC_W'(TRACE_LIMIT))
        begin
            s.tf = 1'b1;
            if (flt == dems_pkg::FLT_NONE)
            begin
                s.fault = dems_pkg::FLT_TRACE;
            end
            s.res.event_kind     = dems_pkg::EV_FAULT;
            s.res.event_endpoint = ep;
            s.res.peer_endpoint  = ep;
            s.res.fault_code     = s.fault;
        end
        else
        begin
            s.evc                = evc + 1'b1;
            s.res.event_kind     = kind;
            s.res.event_endpoint = ep;
            s.res.peer_endpoint  = peer;
            s.res.out_length     = len;
            s.res.out_payload    = pay;
            s.res.fault_code     = (kind == dems_pkg::EV_FAULT) ? flt : dems_pkg::FLT_NONE;
        end
        return s;
    endfunction

    dems_pkg::back_state_t state_reg;
    dems_pkg::back_state_t state_next;

    logic                next_ep_reg;
    logic                next_ep_next;
    logic [2:0]          fault_reg;
    logic [EVC_W-1:0]    evc_reg;
    logic                tf_reg;
    logic                booted_reg;
    logic                booted_next;
    logic [1:0]          ep_flt_reg;
    logic [1:0]          ep_flt_next;
    logic [1:0]          waiting_reg;
    logic [1:0]          waiting_next;
    logic [SLOT_W-1:0]   head_reg  [2];
    logic [SLOT_W-1:0]   head_next [2];
    logic [CNT_W-1:0]    count_reg  [2];
    logic [CNT_W-1:0]    count_next [2];
    logic [1:0]          n_reg;
    logic [1:0]          idx_reg;
    logic                out_valid_reg;
    dems_pkg::evt_item_t out_data_reg;
    dems_pkg::cmd_t      cmd_reg;
    dems_pkg::evt_item_t res_reg [3];

    logic [ENTRY_W-1:0]  mem [MEM_DEPTH];
    logic [ENTRY_W-1:0]  rd_data_reg;
    logic [SLOT_W:0]     rd_addr;
    logic [SLOT_W:0]     wr_addr;
    logic                mem_wr;
    logic                exec_en;
    logic                load;

    // execution results
    rec_step_t           step;
    dems_pkg::evt_item_t res_v [3];
    logic [1:0]          n_v;
    logic [EVC_W-1:0]    ev_v;
    logic [2:0]          lf_v;
    logic                tf_v;
    logic                push_v;
    logic [SLOT_W-1:0]   tail_slot;
    logic [SLOT_W:0]     tail_sum;
    logic                ep;
    logic                id;
    logic                snd;

    assign faulted = tf_reg || ep_flt_reg[0] || ep_flt_reg[1];
    assign ep      = cmd_reg.endpoint;
    assign id      = next_ep_reg;
    assign snd     = ~next_ep_reg;

    // tail slot of the sender queue, head plus count wrapped once
    always_comb
    begin
        tail_sum = {1'b0, head_reg[ep]} + (SLOT_W + 1)'(count_reg[ep]);
        if (tail_sum >= (SLOT_W + 1)'(QUEUE_DEPTH))
        begin
            tail_sum = tail_sum - (SLOT_W + 1)'(QUEUE_DEPTH);
        end
        tail_slot = tail_sum[SLOT_W-1:0];
    end

    assign rd_addr = {snd, head_reg[snd]};
    assign wr_addr = {ep, tail_slot};

    // command execution, one item at a time
    always_comb
    begin
        step         = '0;
        res_v        = '{default: '0};
        n_v          = 2'd0;
        ev_v         = evc_reg;
        lf_v         = fault_reg;
        tf_v         = tf_reg;
        push_v       = 1'b0;
        next_ep_next = next_ep_reg;
        booted_next  = booted_reg;
        ep_flt_next  = ep_flt_reg;
        waiting_next = waiting_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        if (!faulted)
        begin
            case (cmd_reg.op)
                dems_pkg::CMD_BOOT:
                begin
                    booted_next = 1'b1;
                    step = record_event(dems_pkg::EV_BOOT, ep, ep, 8'd0, 64'd0,
                                        ev_v, lf_v, tf_v);
                    res_v[0] = step.res;
                    ev_v = step.evc; lf_v = step.fault; tf_v = step.tf;
                    n_v = 2'd1;
                end
                dems_pkg::CMD_SEND:
                begin
                    if (count_reg[ep] >= CNT_W'(QUEUE_DEPTH))
                    begin
                        waiting_next[ep] = 1'b1;
                        step = record_event(dems_pkg::EV_FULL, ep, ~ep, cmd_reg.msg_length,
                                            cmd_reg.msg_payload, ev_v, lf_v, tf_v);
                    end
                    else
                    begin
                        push_v         = 1'b1;
                        count_next[ep] = count_reg[ep] + 1'b1;
                        step = record_event(dems_pkg::EV_SEND, ep, ~ep, cmd_reg.msg_length,
                                            cmd_reg.msg_payload, ev_v, lf_v, tf_v);
                    end
                    res_v[0] = step.res;
                    ev_v = step.evc; lf_v = step.fault; tf_v = step.tf;
                    n_v = 2'd1;
                end
                dems_pkg::CMD_TURN:
                begin
                    if (booted_reg)
                    begin
                        next_ep_next = snd;
                        step = record_event(dems_pkg::EV_TURN, id, id, 8'd0, 64'd0,
                                            ev_v, lf_v, tf_v);
                        res_v[0] = step.res;
                        ev_v = step.evc; lf_v = step.fault; tf_v = step.tf;
                        n_v = 2'd1;
                        if (!tf_v)
                        begin
                            if (waiting_reg[id] && count_reg[id] < CNT_W'(QUEUE_DEPTH))
                            begin
                                waiting_next[id] = 1'b0;
                                if (!cmd_reg.wr_vec)
                                begin
                                    lf_v            = dems_pkg::FLT_NO_WR;
                                    ep_flt_next[id] = 1'b1;
                                    step = record_event(dems_pkg::EV_FAULT, id, id, 8'd0,
                                                        64'd0, ev_v, lf_v, tf_v);
                                end
                                else
                                begin
                                    step = record_event(dems_pkg::EV_WRITABLE, id, id, 8'd0,
                                                        64'd0, ev_v, lf_v, tf_v);
                                end
                                res_v[1] = step.res;
                                ev_v = step.evc; lf_v = step.fault; tf_v = step.tf;
                                n_v = 2'd2;
                            end
                            else if (count_reg[snd] == '0)
                            begin
                                step = record_event(dems_pkg::EV_IDLE, id, id, 8'd0, 64'd0,
                                                    ev_v, lf_v, tf_v);
                                res_v[1] = step.res;
                                ev_v = step.evc; lf_v = step.fault; tf_v = step.tf;
                                n_v = 2'd2;
                            end
                            else
                            begin
                                // deliver from the head of the peer queue
                                head_next[snd] = (head_reg[snd] == SLOT_W'(QUEUE_DEPTH - 1)) ?
                                                 '0 : head_reg[snd] + 1'b1;
                                count_next[snd] = count_reg[snd] - 1'b1;
                                step = record_event(dems_pkg::EV_DELIVER, snd, id,
                                                    rd_data_reg[ENTRY_W-1 -: 8],
                                                    rd_data_reg[63:0], ev_v, lf_v, tf_v);
                                res_v[1] = step.res;
                                ev_v = step.evc; lf_v = step.fault; tf_v = step.tf;
                                n_v = 2'd2;
                                if (!tf_v && !cmd_reg.rx_vec)
                                begin
                                    lf_v            = dems_pkg::FLT_NO_RX;
                                    ep_flt_next[id] = 1'b1;
                                    step = record_event(dems_pkg::EV_FAULT, id, id, 8'd0,
                                                        64'd0, ev_v, lf_v, tf_v);
                                    res_v[2] = step.res;
                                    ev_v = step.evc; lf_v = step.fault; tf_v = step.tf;
                                    n_v = 2'd3;
                                end
                            end
                        end
                    end
                end
                default:
                begin
                    // run stopped at the instruction limit
                    lf_v            = dems_pkg::FLT_LIMIT;
                    ep_flt_next[ep] = 1'b1;
                    step = record_event(dems_pkg::EV_FAULT, ep, ep, 8'd0, 64'd0,
                                        ev_v, lf_v, tf_v);
                    res_v[0] = step.res;
                    ev_v = step.evc; lf_v = step.fault; tf_v = step.tf;
                    n_v = 2'd1;
                end
            endcase
        end
        for (int k = 0; k < 3; k++)
        begin
            res_v[k].step_ok = !(tf_v || ep_flt_next[0] || ep_flt_next[1]);
            res_v[k].last    = (2'(k) == n_v - 2'd1);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dems_pkg::BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = dems_pkg::BK_EXEC;
                end
            end
            dems_pkg::BK_EXEC:
            begin
                state_next = (n_v == 2'd0) ? dems_pkg::BK_IDLE : dems_pkg::BK_EMIT;
            end
            dems_pkg::BK_EMIT:
            begin
                if (load && idx_reg == n_reg - 2'd1)
                begin
                    state_next = dems_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = dems_pkg::BK_IDLE;
            end
        endcase
    end

    // fsm outputs
    always_comb
    begin
        cmd_pop = 1'b0;
        exec_en = 1'b0;
        load    = 1'b0;
        mem_wr  = 1'b0;
        case (state_reg)
            dems_pkg::BK_IDLE:
            begin
                cmd_pop = cmd_valid;
            end
            dems_pkg::BK_EXEC:
            begin
                exec_en = 1'b1;
                mem_wr  = push_v;
            end
            dems_pkg::BK_EMIT:
            begin
                load = !out_valid_reg || evt_ready;
            end
            default:
            begin
                cmd_pop = 1'b0;
            end
        endcase
    end

    assign evt_valid = out_valid_reg;
    assign evt       = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dems_pkg::BK_IDLE;
            next_ep_reg   <= 1'b1;
            fault_reg     <= dems_pkg::FLT_NONE;
            evc_reg       <= '0;
            tf_reg        <= 1'b0;
            booted_reg    <= 1'b0;
            ep_flt_reg    <= '0;
            waiting_reg   <= '0;
            head_reg      <= '{default: '0};
            count_reg     <= '{default: '0};
            n_reg         <= 2'd0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (exec_en)
            begin
                next_ep_reg <= next_ep_next;
                fault_reg   <= lf_v;
                evc_reg     <= ev_v;
                tf_reg      <= tf_v;
                booted_reg  <= booted_next;
                ep_flt_reg  <= ep_flt_next;
                waiting_reg <= waiting_next;
                head_reg    <= head_next;
                count_reg   <= count_next;
                n_reg       <= n_v;
                idx_reg     <= 2'd0;
            end
            else if (load)
            begin
                idx_reg <= idx_reg + 2'd1;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (evt_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cmd_reg <= cmd;
        end
        if (exec_en)
        begin
            res_reg <= res_v;
        end
        if (load)
        begin
            out_data_reg <= res_reg[idx_reg];
        end
    end

    // message store, both endpoint rings
    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            mem[wr_addr] <= {cmd_reg.msg_length, cmd_reg.msg_payload};
        end
        if (cmd_pop)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

FILE: hdl/dual_endpoint_mailbox_scheduler.sv
// top level of the dual endpoint mailbox scheduler
//
// usage: the host offers request transactions (boot, send, scheduler turn, run
// finished) on req with req_valid/req_ready; each request yields zero to three
// event transactions on evt with evt_valid/evt_ready, the final one marked last.
// endpoints A and B each own a ring of QUEUE_DEPTH messages; turns alternate
// starting with B, and the first fault stops the block for good.
// an accepted request passes through the command queue and the command
// register, then its events through the result and output registers.
// the executor takes one request at a time through fetch, execute and emit
// steps, emitting one event per cycle while evt_ready allows; a two-entry
// command queue in front lets requests arrive meanwhile.
// reset: rings empty, no sender waiting, next turn is B, no fault, not booted,
// event budget full at TRACE_LIMIT events.
// stall: when evt_ready is low the output register holds its event, the
// executor waits, and req_ready drops once the command queue is full.
module dual_endpoint_mailbox_scheduler #(
    parameter int QUEUE_DEPTH = dems_pkg::QUEUE_DEPTH_DEF,
    parameter int TRACE_LIMIT = dems_pkg::TRACE_LIMIT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  dems_pkg::req_item_t req,
    output logic                evt_valid,
    input  logic                evt_ready,
    output dems_pkg::evt_item_t evt
);

    // front to back command path
    logic           cmd_valid;
    logic           cmd_pop;
    dems_pkg::cmd_t cmd;
    logic           faulted;

    // accepts and classifies requests, runs idle-free of the executor
    dems_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd)
    );

    // executes commands against queues, fault latch and event budget
    dems_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TRACE_LIMIT (TRACE_LIMIT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .evt       (evt),
        .faulted   (faulted)
    );

    // a fault never clears short of reset
    assert property (@(posedge clk) disable iff (!rst_n) faulted |=> faulted)
        else $error("fault state cleared");

    // a fault event closes its transaction group and reports failure
    assert property (@(posedge clk) disable iff (!rst_n)
        (evt_valid && evt.event_kind == dems_pkg::EV_FAULT) |->
        (evt.last && !evt.step_ok && evt.fault_code != dems_pkg::FLT_NONE))
        else $error("malformed fault event");

    // a failed step is only reported once the block is faulted
    assert property (@(posedge clk) disable iff (!rst_n)
        (evt_valid && !evt.step_ok) |-> faulted)
        else $error("step failure without fault");

endmodule
